// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 16;

  // fixed widths of the word fields
  localparam int KEY_FIELD_BITS = 16;
  localparam int ID_FIELD_BITS  = 16;
  localparam int OCC_BITS       = 5;

  // occupancy counter must hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                      command;
    logic [KEY_FIELD_BITS-1:0] key_value;
    logic [ID_FIELD_BITS-1:0]  entry_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ID_FIELD_BITS-1:0] removed_id;
    logic [OCC_BITS-1:0]      occupancy;
  } res_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } cell_ctl_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Slot 0 holds the smallest key; keys do not
// decrease toward higher slots, and among equal keys the newest sits lowest.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::cell_ctl_t           ctl,
  input  logic                         occupied,
  input  logic                         lower_lt,
  input  logic [spq_pkg::KEY_BITS-1:0] lower_key,
  input  logic [spq_pkg::ID_BITS-1:0]  lower_id,
  input  logic [spq_pkg::KEY_BITS-1:0] upper_key,
  input  logic [spq_pkg::ID_BITS-1:0]  upper_id,
  output logic                         lt,
  output logic [spq_pkg::KEY_BITS-1:0] key,
  output logic [spq_pkg::ID_BITS-1:0]  id
);

  // stored key is below the new key, so this slot stays put on insert
  assign lt = occupied && (key < ctl.key);

  always_ff @(posedge clk) begin
    case (ctl.op)
      spq_pkg::OP_INSERT: begin
        if (!lt) begin
          if (lower_lt) begin
            key <= ctl.key;
            id  <= ctl.id;
          end else begin
            key <= lower_key;
            id  <= lower_id;
          end
        end
      end
      spq_pkg::OP_REMOVE: begin
        key <= upper_key;
        id  <= upper_id;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of (key, id) entries held in a chain of cells,
// extracting the smallest key, newest first among equal keys.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------
//  cmd     | cmd_valid / cmd_ready | command, key_value, entry_id
//  res     | res_valid / res_ready | status, removed_id, occupancy
//
// one command per cycle while results are taken: every cell compares against the
// new key at once and shifts or loads in the same cycle.
// the result sits in an output register in the cycle after acceptance; a new
// command is taken whenever that register is empty or being drained.
// a stalled res channel holds cmd_ready low until the result is taken.
// reset clears the entry count and the output valid; slot contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  spq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output spq_pkg::res_t res
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  spq_pkg::res_t             res_next;
  spq_pkg::cell_ctl_t        ctl;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;

  logic                         lt_chain  [0:spq_pkg::DEPTH];
  logic [spq_pkg::KEY_BITS-1:0] key_chain [0:spq_pkg::DEPTH];
  logic [spq_pkg::ID_BITS-1:0]  id_chain  [0:spq_pkg::DEPTH];

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign is_full   = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign is_empty  = (count == '0);

  // sentinel below slot 0 acts as a key smaller than anything
  assign lt_chain[0]  = 1'b1;
  assign key_chain[0] = '0;
  assign id_chain[0]  = '0;

  always_comb begin
    ctl.key    = spq_pkg::KEY_BITS'(cmd.key_value);
    ctl.id     = spq_pkg::ID_BITS'(cmd.entry_id);
    ctl.op     = spq_pkg::OP_HOLD;
    count_next = count;
    res_next.status     = spq_pkg::ST_OK;
    res_next.removed_id = '0;
    if (accept) begin
      if (cmd.command == spq_pkg::CMD_INSERT) begin
        if (is_full) begin
          res_next.status = spq_pkg::ST_FULL;
        end else begin
          ctl.op     = spq_pkg::OP_INSERT;
          count_next = count + spq_pkg::CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          res_next.status = spq_pkg::ST_EMPTY;
        end else begin
          ctl.op              = spq_pkg::OP_REMOVE;
          count_next          = count - spq_pkg::CNT_W'(1);
          res_next.removed_id = spq_pkg::ID_FIELD_BITS'(id_chain[1]);
        end
      end
    end
    res_next.occupancy = spq_pkg::OCC_BITS'(count_next);
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    localparam int UP = (i + 2 > spq_pkg::DEPTH) ? spq_pkg::DEPTH : i + 2;
    logic occupied;

    assign occupied = (count > spq_pkg::CNT_W'(i));

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied),
      .lower_lt  (lt_chain[i]),
      .lower_key (key_chain[i]),
      .lower_id  (id_chain[i]),
      .upper_key (key_chain[UP]),
      .upper_id  (id_chain[UP]),
      .lt        (lt_chain[i+1]),
      .key       (key_chain[i+1]),
      .id        (id_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == spq_pkg::CMD_INSERT && is_full) |=>
      (res.status == spq_pkg::ST_FULL && $stable(count)))
    else $error("insert into full queue changed the store");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == spq_pkg::ST_EMPTY) |->
      (res.occupancy == '0 && res.removed_id == '0))
    else $error("empty result with entries or id");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (res.occupancy == spq_pkg::OCC_BITS'(count)))
    else $error("reported occupancy differs from entry count");

endmodule

// ===== bench/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue and keeps its own copy
// of the sorted store. Every accepted command word is turned into the
// result it must produce. Every result word is checked against the oldest
// result still owed.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  spq_pkg::cmd_t cmd,
  input  logic          res_valid,
  input  logic          res_ready,
  input  spq_pkg::res_t res,
  output int            mismatches,
  output int            outstanding
);

  // slot 0 holds the largest key, the last occupied slot the smallest
  logic [spq_pkg::KEY_BITS-1:0] slot_key [spq_pkg::DEPTH];
  logic [spq_pkg::ID_BITS-1:0]  slot_id  [spq_pkg::DEPTH];
  int                           stored;
  spq_pkg::res_t                owed_results [$];

  function automatic spq_pkg::res_t apply_command(input spq_pkg::cmd_t w);
    spq_pkg::res_t                r;
    int                           pos;
    logic [spq_pkg::KEY_BITS-1:0] k;
    r        = '0;
    r.status = spq_pkg::ST_OK;
    k        = w.key_value[spq_pkg::KEY_BITS-1:0];
    if (w.command == spq_pkg::CMD_INSERT) begin
      if (stored >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // new entry goes behind every entry with a key greater or equal
        pos = 0;
        while (pos < stored && slot_key[pos] >= k) pos++;
        for (int i = stored; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_id[i]  = slot_id[i-1];
        end
        slot_key[pos] = k;
        slot_id[pos]  = w.entry_id[spq_pkg::ID_BITS-1:0];
        stored++;
      end
    end else if (stored == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      stored--;
      r.removed_id = spq_pkg::ID_FIELD_BITS'(slot_id[stored]);
    end
    r.occupancy = spq_pkg::OCC_BITS'(stored);
    return r;
  endfunction

  always @(posedge clk) begin
    spq_pkg::res_t want;
    if (rst) begin
      stored = 0;
      owed_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $error("result word with no command waiting: status %0d id %0h occupancy %0d",
                 res.status, res.removed_id, res.occupancy);
        end else begin
          want = owed_results.pop_front();
          if (res.status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, res.status);
          end
          if (res.removed_id !== want.removed_id) begin
            mismatches++;
            $error("removed_id: expected %0h, got %0h", want.removed_id, res.removed_id);
          end
          if (res.occupancy !== want.occupancy) begin
            mismatches++;
            $error("occupancy: expected %0d, got %0d", want.occupancy, res.occupancy);
          end
        end
      end
      if (cmd_valid && cmd_ready) owed_results.push_back(apply_command(cmd));
    end
    outstanding = owed_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the sorted priority queue and drains its result
// words. A directed opening covers empty and full queues, extreme keys and
// ids, and ties on equal keys. Random phases then lean toward filling,
// draining or mixing, with random gaps on both channels, two long result
// stalls and pauses until the queue has answered everything.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_WORDS = 750;
  localparam int CALM_AFTER   = 650;
  localparam int LONG_STALL   = 80;

  logic          clk;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  spq_pkg::cmd_t cmd       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  spq_pkg::res_t res;

  int   mismatches;
  int   outstanding;
  int   words_sent = 0;
  logic calm       = 1'b0;
  // long stalls asked for by the sender and served by the drain
  int   long_asked = 0;
  int   long_done  = 0;

  sorted_priority_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  spq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_600_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic spq_pkg::cmd_t make_insert(input logic [15:0] k,
                                                input logic [15:0] d);
    spq_pkg::cmd_t w;
    w.command   = spq_pkg::CMD_INSERT;
    w.key_value = k;
    w.entry_id  = d;
    return w;
  endfunction

  // key and id are don't-care on a remove, so they carry noise
  function automatic spq_pkg::cmd_t make_remove();
    spq_pkg::cmd_t w;
    w.command   = spq_pkg::CMD_REMOVE;
    w.key_value = 16'($urandom);
    w.entry_id  = 16'($urandom);
    return w;
  endfunction

  // narrow range makes ties common
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 4))
      0, 1:    return 16'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input spq_pkg::cmd_t w);
    logic taken;
    cmd       <= w;
    cmd_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cmd_ready;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  task automatic idle_gap(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_answered();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin : result_drain
    do @(posedge clk); while (rst);
    forever begin
      if (long_done != long_asked) begin
        res_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_done++;
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase_no;
    int phase_len;
    int insert_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // remove from an empty queue
    send_word(make_remove());
    // fill with extremes and ties on smallest, middle and largest keys
    send_word(make_insert(16'hFFFF, 16'h0000));
    send_word(make_insert(16'h0000, 16'hFFFF));
    send_word(make_insert(16'h0000, 16'h0001));
    send_word(make_insert(16'h8000, 16'h5555));
    send_word(make_insert(16'h7FFF, 16'hAAAA));
    send_word(make_insert(16'h8000, 16'h1234));
    send_word(make_insert(16'hFFFF, 16'h0F0F));
    for (int i = 1; i <= 9; i++) begin
      send_word(make_insert(16'(i * 16'h1111), 16'(16'hF000 + i)));
    end
    // queue is full now, this word is dropped
    send_word(make_insert(16'h1234, 16'h4321));
    for (int i = 0; i < 4; i++) send_word(make_remove());
    wait_all_answered();

    phase_no   = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      phase_no++;
      if (words_sent >= CALM_AFTER) calm <= 1'b1;
      if (phase_no == 6 || phase_no == 16) long_asked++;
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      phase_len = $urandom_range(10, 40);
      repeat (phase_len) begin
        if (!calm && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 10));
        if ($urandom_range(1, 100) <= insert_pct)
          send_word(make_insert(pick_key(), 16'($urandom)));
        else
          send_word(make_remove());
      end
      if (phase_no % 6 == 0) wait_all_answered();
    end

    wait_all_answered();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
